FILE: rtl/srrw_pkg.sv
// Shared types and constants for the selective-repeat receive window.
`timescale 1ns / 1ps

package srrw_pkg;

    localparam int DEF_WINDOW_DEPTH = 4;
    localparam int DEF_SEQ_SPACE    = 8;

    localparam int SEQ_NUM_W = 3;
    localparam int PAYLOAD_W = 32;
    localparam int WSIZE_W   = 3;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 3'd4;

    typedef struct packed {
        logic [SEQ_NUM_W-1:0] seq_num;
        logic [PAYLOAD_W-1:0] payload_ref;
    } t_pkt;

    typedef struct packed {
        logic                 accepted;
        logic                 in_previous;
        logic                 deliver_valid;
        logic [SEQ_NUM_W-1:0] deliver_seq;
        logic [PAYLOAD_W-1:0] deliver_payload;
        logic                 last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the arriving packet
        logic norm;      // reduce head by one window size
        logic judge;     // latch window flags
        logic store;     // write the packet into its slot
        logic status;    // emit a status-only result
        logic deliver;   // emit the head slot and advance
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic head_ge_w;
        logic in_win;
        logic head_filled;
        logic dlv_last;
    } t_sts;

endpackage

FILE: rtl/srrw_ctrl.sv
// Sequencer for packet check, slot store and in-order delivery.
`timescale 1ns / 1ps

module srrw_ctrl
    import srrw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DLV
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.head_ge_w) begin
                    o_cmd.norm = 1'b1;
                end else if (i_sts.in_win) begin
                    o_cmd.judge = 1'b1;
                    o_cmd.store = 1'b1;
                    n_state     = S_CHECK;
                end else begin
                    o_cmd.judge  = 1'b1;
                    o_cmd.status = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.head_filled) begin
                    n_state = S_DLV;
                end else begin
                    o_cmd.status = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DLV: begin
                o_cmd.deliver = 1'b1;
                if (i_sts.dlv_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: rtl/srrw_dpath.sv
// Window registers, slot store, filled marks and result register.
`timescale 1ns / 1ps

module srrw_dpath
    import srrw_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int SEQ_SPACE    = DEF_SEQ_SPACE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pkt               i_pkt,
    input  logic               i_cfg_valid,
    input  logic [WSIZE_W-1:0] i_cfg_data,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_res_strobe,
    output t_res               o_res
);

    localparam int SEQ_W  = $clog2(SEQ_SPACE);
    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CAP    = (WINDOW_DEPTH < SEQ_SPACE) ? WINDOW_DEPTH : SEQ_SPACE;
    localparam int WIN_W  = $clog2(CAP + 1);
    localparam int CW     = SEQ_W + WIN_W + 4;

    localparam logic [CW-1:0] S_X   = CW'(SEQ_SPACE);
    localparam logic [CW-1:0] CAP_X = CW'(CAP);
    localparam logic [CW-1:0] ONE_X = CW'(1);

    logic [WSIZE_W-1:0]   r_wsize;
    logic [SEQ_NUM_W-1:0] r_seq;
    logic [PAYLOAD_W-1:0] r_pay;
    logic [SEQ_W-1:0]     r_base;
    logic [HEAD_W-1:0]    r_head, r_hw, n_hw;
    logic [WIN_W-1:0]     r_cnt;
    logic                 r_acc, r_prev;
    logic [WINDOW_DEPTH-1:0] r_filled;
    logic [PAYLOAD_W-1:0] r_mem [WINDOW_DEPTH];
    logic [PAYLOAD_W-1:0] r_rd;
    logic                 r_strobe;
    t_res                 r_res;

    logic [CW-1:0] ws_x, w_x, seq_x, base_x, head_x, cnt_x;
    logic [CW-1:0] fwd_x, back_x, sum_x, idx_x, hinc_x, hn_x, binc_x;
    logic [HEAD_W-1:0] idx, hn;
    logic in_range, acc_c, prev_c;

    always_comb begin
        ws_x   = CW'(r_wsize);
        w_x    = (ws_x == '0) ? ONE_X : ((ws_x > CAP_X) ? CAP_X : ws_x);
        seq_x  = CW'(r_seq);
        base_x = CW'(r_base);
        // working head: a copy of the stored head, reduced below w for this packet only
        head_x = CW'(r_hw);
        cnt_x  = CW'(r_cnt);

        in_range = (seq_x < S_X);
        fwd_x    = (seq_x >= base_x) ? (seq_x - base_x) : (seq_x + S_X - base_x);
        back_x   = (base_x >= seq_x) ? (base_x - seq_x) : (base_x + S_X - seq_x);
        acc_c    = in_range && (fwd_x < w_x);
        prev_c   = in_range && (back_x != '0) && (back_x <= w_x);

        // head is already below w here, fwd too, so one subtract wraps the sum
        sum_x = head_x + fwd_x;
        idx_x = (sum_x >= w_x) ? (sum_x - w_x) : sum_x;
        idx   = idx_x[HEAD_W-1:0];

        hinc_x = head_x + ONE_X;
        hn_x   = (hinc_x == w_x) ? '0 : hinc_x;
        hn     = hn_x[HEAD_W-1:0];

        binc_x = base_x + ONE_X;

        n_hw = r_hw;
        if (i_cmd.norm) begin
            n_hw = HEAD_W'(head_x - w_x);
        end else if (i_cmd.deliver) begin
            n_hw = hn;
        end
    end

    assign o_sts.head_ge_w   = (head_x >= w_x);
    assign o_sts.in_win      = acc_c;
    assign o_sts.head_filled = r_filled[r_hw];
    assign o_sts.dlv_last    = ((cnt_x + ONE_X) == w_x) || !r_filled[hn];

    // slot store: one write port, read port follows the next head
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[idx] <= r_pay;
        end
        r_rd <= r_mem[n_hw];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize  <= WSIZE_RESET;
            r_base   <= '0;
            r_head   <= '0;
            r_hw     <= '0;
            r_filled <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wsize <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_hw <= r_head;
            end else begin
                r_hw <= n_hw;
            end
            if (i_cmd.store) begin
                r_filled[idx] <= 1'b1;
            end
            // advance the stored head only on a delivery
            if (i_cmd.deliver) begin
                r_filled[r_hw] <= 1'b0;
                r_head <= hn;
                r_base <= (binc_x == S_X) ? '0 : binc_x[SEQ_W-1:0];
            end
            r_strobe <= i_cmd.status | i_cmd.deliver;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq <= i_pkt.seq_num;
            r_pay <= i_pkt.payload_ref;
            r_cnt <= '0;
        end
        if (i_cmd.judge) begin
            r_acc  <= acc_c;
            r_prev <= prev_c;
        end
        if (i_cmd.deliver) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.status) begin
            r_res.accepted        <= i_cmd.judge ? acc_c : r_acc;
            r_res.in_previous     <= i_cmd.judge ? prev_c : r_prev;
            r_res.deliver_valid   <= 1'b0;
            r_res.deliver_seq     <= '0;
            r_res.deliver_payload <= '0;
            r_res.last            <= 1'b1;
        end else if (i_cmd.deliver) begin
            r_res.accepted        <= r_acc;
            r_res.in_previous     <= r_prev;
            r_res.deliver_valid   <= 1'b1;
            r_res.deliver_seq     <= base_x[SEQ_NUM_W-1:0];
            r_res.deliver_payload <= r_rd;
            r_res.last            <= o_sts.dlv_last;
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_res.last |=> r_strobe)
        else $error("delivery burst broken before its last beat");

    a_delivery_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_res.deliver_valid |-> r_res.accepted)
        else $error("delivery from a packet outside the window");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_res.deliver_valid |-> r_res.last)
        else $error("status-only beat not flagged last");

    a_deliver_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deliver |-> r_filled[r_hw])
        else $error("delivering an empty slot");

endmodule

FILE: rtl/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window.
//
//  channel   direction  handshake                       payload
//  packet    in         i_start high, o_busy low        i_pkt (t_pkt)
//  result    out        o_res_strobe, one cycle         o_res (t_res)
//  config    in         i_cfg_valid and o_cfg_ready     i_cfg_data (window size)
//
// After a packet beat the block is busy: a rejected packet ends with a status
// result, a stored packet goes through a head check and then gives a status
// result or its in-order deliveries (one slot per cycle through the single slot
// read port); while the stored head is at or above the window size, until a
// delivery wraps it, each packet first lowers a working head by window sizes.
// Reset is synchronous; it clears filled marks, head, base and sets window size 4.
// Results cannot be stalled: each beat shows for exactly one cycle.
`timescale 1ns / 1ps

module selective_repeat_receive_window
    import srrw_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int SEQ_SPACE    = DEF_SEQ_SPACE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  t_pkt               i_pkt,
    output logic               o_res_strobe,
    output t_res               o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [WSIZE_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    srrw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    srrw_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SEQ_SPACE    (SEQ_SPACE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (i_pkt),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule
